// ===== design/swrk_pkg.sv =====
`default_nettype none
package swrk_pkg;

	// Storage geometry
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	// Fixed field widths of the channels
	localparam int FIELD_W = 32;
	localparam int OP_W    = 2;
	localparam int K_W     = 5;

	// Derived widths
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (K_W > CNT_W) ? K_W : CNT_W;

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [IDX_W-1:0]      idx_t;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_PEEK   = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	// Per-cycle command broadcast along the row of cells
	typedef struct packed {
		logic push;   // every cell takes its upper neighbour's word
		logic pull;   // cells at or below sel take their lower neighbour's word
		idx_t sel;    // cell whose word is read out
	} cell_cmd_t;

	// Keep the low DATA_WIDTH bits of a pushed field
	function automatic word_t to_word(input logic signed [FIELD_W-1:0] v);
		logic signed [FIELD_W+DATA_WIDTH-1:0] wide;
		wide = (FIELD_W + DATA_WIDTH)'(v);
		return wide[DATA_WIDTH-1:0];
	endfunction

	// Sign-extend a stored word and cut it to the field width
	function automatic logic signed [FIELD_W-1:0] to_field(input word_t w);
		logic signed [FIELD_W+DATA_WIDTH-1:0] wide;
		wide = (FIELD_W + DATA_WIDTH)'(signed'(w));
		return wide[FIELD_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/swrk_req_if.sv =====
`default_nettype none
interface swrk_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [swrk_pkg::OP_W-1:0]               op;
	logic signed [swrk_pkg::FIELD_W-1:0]     push_value;
	logic [swrk_pkg::K_W-1:0]                position_k;

	modport source (output valid, output op, output push_value, output position_k,
		input ready);
	modport sink (input valid, input op, input push_value, input position_k,
		output ready);
endinterface
`default_nettype wire

// ===== design/swrk_rsp_if.sv =====
`default_nettype none
interface swrk_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                ok;
	logic signed [swrk_pkg::FIELD_W-1:0] read_value;
	logic                                is_empty;

	modport source (output valid, output ok, output read_value, output is_empty,
		input ready);
	modport sink (input valid, input ok, input read_value, input is_empty,
		output ready);
endinterface
`default_nettype wire

// ===== design/swrk_cell.sv =====
`default_nettype none
module swrk_cell (
	input  wire logic                clk,
	input  wire swrk_pkg::cell_cmd_t cmd,
	input  wire swrk_pkg::idx_t      idx,
	input  wire swrk_pkg::word_t     up_word,
	input  wire swrk_pkg::word_t     down_word,
	output swrk_pkg::word_t          word,
	output swrk_pkg::word_t          hit_word
);
	swrk_pkg::word_t word_q;

	// Push moves the whole row down; pull closes the gap from the selected cell on
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			word_q <= up_word;
		end else if (cmd.pull && idx >= cmd.sel) begin
			word_q <= down_word;
		end
	end

	assign word     = word_q;
	assign hit_word = (idx == cmd.sel) ? word_q : '0;
endmodule
`default_nettype wire

// ===== design/swrk_ctrl.sv =====
`default_nettype none
module swrk_ctrl (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	input  wire logic [swrk_pkg::OP_W-1:0]           req_op,
	input  wire logic [swrk_pkg::K_W-1:0]            req_k,
	input  wire logic                                rsp_ready,
	input  wire swrk_pkg::word_t                     sel_word,
	output logic                                     req_ready,
	output swrk_pkg::cell_cmd_t                      cmd,
	output logic                                     rsp_valid,
	output logic                                     rsp_ok,
	output logic signed [swrk_pkg::FIELD_W-1:0]      rsp_read_value,
	output logic                                     rsp_is_empty
);
	swrk_pkg::cnt_t count_q;
	swrk_pkg::cnt_t count_d;
	logic           valid_q;
	logic           ok_q;
	logic           empty_q;
	logic signed [swrk_pkg::FIELD_W-1:0] read_q;

	logic           accept;
	logic           ok;
	logic           reads;
	logic           full;
	logic           empty;
	logic           k_in_range;
	swrk_pkg::op_t  op;

	assign req_ready = !valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign op        = swrk_pkg::op_t'(req_op);
	assign full      = (count_q == swrk_pkg::cnt_t'(swrk_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign k_in_range = (req_k != '0) &&
		(swrk_pkg::CMP_W'(req_k) <= swrk_pkg::CMP_W'(count_q));

	always_comb begin
		ok       = 1'b0;
		reads    = 1'b0;
		cmd      = '0;
		count_d  = count_q;
		unique case (op)
			swrk_pkg::OP_PUSH: begin
				ok       = !full;
				cmd.push = accept && !full;
				if (accept && !full) begin
					count_d = count_q + 1'b1;
				end
			end
			swrk_pkg::OP_POP: begin
				ok       = !empty;
				reads    = 1'b1;
				cmd.pull = accept && !empty;
				if (accept && !empty) begin
					count_d = count_q - 1'b1;
				end
			end
			swrk_pkg::OP_PEEK: begin
				ok    = !empty;
				reads = 1'b1;
			end
			swrk_pkg::OP_REMOVE: begin
				ok       = k_in_range;
				reads    = 1'b1;
				cmd.sel  = k_in_range ? swrk_pkg::idx_t'(req_k - 1'b1) : '0;
				cmd.pull = accept && k_in_range;
				if (accept && k_in_range) begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				valid_q <= 1'b1;
			end else if (rsp_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q    <= ok;
			read_q  <= (ok && reads) ? swrk_pkg::to_field(sel_word) : '0;
			empty_q <= (count_d == '0);
		end
	end

	assign rsp_valid      = valid_q;
	assign rsp_ok         = ok_q;
	assign rsp_read_value = read_q;
	assign rsp_is_empty   = empty_q;
endmodule
`default_nettype wire

// ===== design/stack_with_remove_kth_top.sv =====
`default_nettype none
// channel | role | payload                           | accepted when
// req     | sink | op, push_value, position_k        | req.valid && req.ready
// rsp     | src  | ok, read_value, is_empty          | rsp.valid && rsp.ready
//
// One item per clock while results are taken: the operation is decided, the row of
// cells updated and the result registered in the cycle the item is accepted.
// The result register frees up as it is taken, so req.ready holds high while
// rsp.ready is high; it drops only while a result waits untaken.
// Reset clears the fill count and the result valid; the cells hold no reset.
module stack_with_remove_kth_top (
	input wire logic   clk,
	input wire logic   arst_n,
	swrk_req_if.sink   req,
	swrk_rsp_if.source rsp
);
	// Cell 0 holds the top of the stack, cell DEPTH-1 the deepest entry.
	swrk_pkg::cell_cmd_t cmd;
	swrk_pkg::word_t     words    [swrk_pkg::DEPTH];
	swrk_pkg::word_t     hits     [swrk_pkg::DEPTH];
	swrk_pkg::word_t     sel_word;
	swrk_pkg::word_t     push_word;

	// Keep the low bits of the pushed field; it enters at the top cell
	assign push_word = swrk_pkg::to_word(req.push_value);

	// Row of cells: each looks only at its two neighbours and the broadcast command
	for (genvar i = 0; i < swrk_pkg::DEPTH; i++) begin : g_cell
		swrk_pkg::word_t up_w;
		swrk_pkg::word_t down_w;

		if (i == 0) begin : g_top
			assign up_w = push_word;
		end else begin : g_mid_up
			assign up_w = words[i-1];
		end

		// The deepest cell has nothing below; hold its own word when pulled
		if (i == swrk_pkg::DEPTH - 1) begin : g_bottom
			assign down_w = words[i];
		end else begin : g_mid_down
			assign down_w = words[i+1];
		end

		swrk_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.idx       (swrk_pkg::idx_t'(i)),
			.up_word   (up_w),
			.down_word (down_w),
			.word      (words[i]),
			.hit_word  (hits[i])
		);
	end

	// Only the selected cell drives a non-zero hit word; merge them
	always_comb begin
		sel_word = '0;
		for (int i = 0; i < swrk_pkg::DEPTH; i++) begin
			sel_word = sel_word | hits[i];
		end
	end

	swrk_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req.valid),
		.req_op         (req.op),
		.req_k          (req.position_k),
		.rsp_ready      (rsp.ready),
		.sel_word       (sel_word),
		.req_ready      (req.ready),
		.cmd            (cmd),
		.rsp_valid      (rsp.valid),
		.rsp_ok         (rsp.ok),
		.rsp_read_value (rsp.read_value),
		.rsp_is_empty   (rsp.is_empty)
	);
endmodule
`default_nettype wire
